// ----- rtl/led_strip_frame_encoder_top_macros.svh -----
// Assertion macros for the LED strip frame encoder.
`ifndef LED_STRIP_FRAME_ENCODER_TOP_MACROS_SVH
`define LED_STRIP_FRAME_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define LSFE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define LSFE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lsfe_pkg.sv -----
// Types, codes and frame constants shared by the LED strip frame encoder.
package lsfe_pkg;

  localparam int BYTE_W     = 8;
  localparam int PIX_W      = 3 * BYTE_W;
  localparam int FRAME_W    = 4 * 8;
  localparam int LED_CNT_W  = 6;
  localparam int ORDER_W    = 2;
  localparam int CFG_DATA_W = LED_CNT_W;
  localparam int REG_IDX_W  = 1;

  localparam logic [BYTE_W-1:0]  LED_HEADER  = 8'hFF;
  localparam logic [FRAME_W-1:0] START_FRAME = 32'h0000_0000;
  localparam logic [FRAME_W-1:0] END_FRAME   = 32'hFFFF_FFFF;

  localparam logic [REG_IDX_W-1:0] REG_LED_COUNT   = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_COLOR_ORDER = 1'b1;

  localparam logic MODE_WRITE   = 1'b0;
  localparam logic MODE_REFRESH = 1'b1;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_FRAME  = 1'b1;

  typedef enum logic [ORDER_W-1:0] {
    ORDER_RGB  = 2'd0,
    ORDER_GRB  = 2'd1,
    ORDER_BGR  = 2'd2,
    ORDER_NONE = 2'd3
  } color_order_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PIXELS,
    ST_END
  } state_t;

  // Byte order as stored; first byte goes out first on the strip.
  function automatic logic [PIX_W-1:0] pack_pixel(color_order_t order,
                                                   logic [BYTE_W-1:0] r,
                                                   logic [BYTE_W-1:0] g,
                                                   logic [BYTE_W-1:0] b);
    logic [PIX_W-1:0] p;
    unique case (order)
      ORDER_RGB:  p = {r, g, b};
      ORDER_GRB:  p = {g, r, b};
      ORDER_BGR:  p = {b, g, r};
      ORDER_NONE: p = '0;
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/led_strip_frame_encoder_top.sv -----
// LED strip frame encoder: pixel memory, write status and refresh streaming.
`include "led_strip_frame_encoder_top_macros.svh"

// A pixel write (mode 0) is answered by one status result in the next cycle;
// busy stays low, so writes can follow back to back. A refresh (mode 1) streams
// a start frame, one frame per LED in use and an end frame (with last set), one
// frame each cycle, paced by the single read port of the pixel memory, and busy
// is high for all but the last of them. Results appear on result_valid for one
// cycle each and cannot be held off. After reset every pixel reads as zero at
// once (per-entry valid bits), so there is no clearing pass. Write led_count and
// color_order only while busy is low and no result is pending.
module led_strip_frame_encoder_top #(
  parameter int MAX_LEDS = 62
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   mode,
  input  logic [7:0]                             pixel_index,
  input  logic [7:0]                             red,
  input  logic [7:0]                             green,
  input  logic [7:0]                             blue,
  input  logic                                   cfg_write,
  input  logic [lsfe_pkg::REG_IDX_W-1:0]         cfg_addr,
  input  logic [lsfe_pkg::CFG_DATA_W-1:0]        cfg_data,
  output logic                                   result_valid,
  output logic                                   kind,
  output logic                                   index_error,
  output logic [lsfe_pkg::FRAME_W-1:0]           frame_word,
  output logic                                   last
);

  localparam int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CNT_W = $clog2(MAX_LEDS + 1);

  // configuration
  logic [lsfe_pkg::LED_CNT_W-1:0] led_count;
  lsfe_pkg::color_order_t         color_order;

  // control
  lsfe_pkg::state_t state, state_next;
  logic [IDX_W-1:0] pos, pos_next;
  logic [CNT_W-1:0] cnt_eff;
  logic             accept;
  logic             idx_err;
  logic             at_last;

  // pixel memory
  logic [lsfe_pkg::PIX_W-1:0] mem [MAX_LEDS];
  logic [MAX_LEDS-1:0]        pix_valid;
  logic                       wr_en;
  logic [IDX_W-1:0]           wr_addr;
  logic [lsfe_pkg::PIX_W-1:0] wr_data;
  logic                       rd_en;
  logic [IDX_W-1:0]           rd_addr;
  logic [lsfe_pkg::PIX_W-1:0] rd_data;
  logic                       rd_hit;

  // result register inputs
  logic                         valid_next;
  logic                         kind_next;
  logic                         err_next;
  logic [lsfe_pkg::FRAME_W-1:0] word_next;
  logic                         last_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      led_count   <= '0;
      color_order <= lsfe_pkg::ORDER_RGB;
    end else if (cfg_write) begin
      priority if (cfg_addr == lsfe_pkg::REG_LED_COUNT) begin
        led_count <= cfg_data;
      end else if (cfg_addr == lsfe_pkg::REG_COLOR_ORDER) begin
        color_order <= lsfe_pkg::color_order_t'(cfg_data[lsfe_pkg::ORDER_W-1:0]);
      end
    end
  end

  assign cnt_eff = (led_count > lsfe_pkg::LED_CNT_W'(MAX_LEDS)) ? CNT_W'(MAX_LEDS)
                                                                  : CNT_W'(led_count);
  assign busy    = (state != lsfe_pkg::ST_IDLE);
  assign accept  = start && !busy;
  assign idx_err = (pixel_index >= 8'(cnt_eff));
  assign at_last = (CNT_W'(pos) == cnt_eff - CNT_W'(1));
  assign wr_addr = pixel_index[IDX_W-1:0];
  assign wr_data = lsfe_pkg::pack_pixel(color_order, red, green, blue);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lsfe_pkg::ST_IDLE: begin
        if (accept && mode == lsfe_pkg::MODE_REFRESH) begin
          state_next = (cnt_eff == '0) ? lsfe_pkg::ST_END : lsfe_pkg::ST_PIXELS;
        end
      end
      lsfe_pkg::ST_PIXELS: begin
        if (at_last) begin
          state_next = lsfe_pkg::ST_END;
        end
      end
      lsfe_pkg::ST_END: begin
        state_next = lsfe_pkg::ST_IDLE;
      end
      default: begin
        state_next = lsfe_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs, memory access and position counter
  always_comb begin
    valid_next = 1'b0;
    kind_next  = lsfe_pkg::KIND_FRAME;
    err_next   = 1'b0;
    word_next  = '0;
    last_next  = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    pos_next   = pos;
    unique case (state)
      lsfe_pkg::ST_IDLE: begin
        if (accept) begin
          valid_next = 1'b1;
          if (mode == lsfe_pkg::MODE_WRITE) begin
            kind_next = lsfe_pkg::KIND_STATUS;
            err_next  = idx_err;
            last_next = 1'b1;
            wr_en     = !idx_err;
          end else begin
            word_next = lsfe_pkg::START_FRAME;
            rd_en     = 1'b1;
            pos_next  = '0;
          end
        end
      end
      lsfe_pkg::ST_PIXELS: begin
        // read data is registered behind the address: fetch the next LED now
        valid_next = 1'b1;
        word_next  = {lsfe_pkg::LED_HEADER, rd_hit ? rd_data : '0};
        if (at_last) begin
          pos_next = '0;
        end else begin
          pos_next = IDX_W'(pos + 1'b1);
          rd_en    = 1'b1;
          rd_addr  = IDX_W'(pos + 1'b1);
        end
      end
      lsfe_pkg::ST_END: begin
        valid_next = 1'b1;
        word_next  = lsfe_pkg::END_FRAME;
        last_next  = 1'b1;
      end
      default: begin
        valid_next = 1'b0;
      end
    endcase
  end

  // writes happen only when idle and reads only during a refresh: no overlap
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= '0;
      rd_hit    <= 1'b0;
    end else begin
      if (wr_en) begin
        pix_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= pix_valid[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= lsfe_pkg::ST_IDLE;
      pos          <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      pos          <= pos_next;
      result_valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    kind        <= kind_next;
    index_error <= err_next;
    frame_word  <= word_next;
    last        <= last_next;
  end

  `LSFE_ASSERT_NXT(a_refresh_starts, accept && mode == lsfe_pkg::MODE_REFRESH, result_valid && kind == lsfe_pkg::KIND_FRAME && frame_word == lsfe_pkg::START_FRAME && !last, "refresh did not open with a start frame")
  `LSFE_ASSERT_NXT(a_write_status, accept && mode == lsfe_pkg::MODE_WRITE, result_valid && kind == lsfe_pkg::KIND_STATUS && last && !busy, "pixel write gave no single status result")
  `LSFE_ASSERT_IMP(a_stream_gapless, busy, result_valid && kind == lsfe_pkg::KIND_FRAME && !last, "gap or early end in refresh stream")
  `LSFE_ASSERT_IMP(a_end_frame, result_valid && kind == lsfe_pkg::KIND_FRAME && last, frame_word == lsfe_pkg::END_FRAME && !busy, "last frame is not the end frame")

endmodule
